// File: sv/ecw_pkg.sv
`timescale 1ns / 1ps

package ecw_pkg;

    localparam int EPOCH_W      = 38;
    localparam int LO_W         = 7;
    localparam int HI_W         = EPOCH_W - LO_W;
    localparam int DAY_DIV      = 675;
    localparam int DAYS_W       = 22;
    localparam int TOD_W        = 17;
    localparam int DAYS_TO_ERA0 = 719468;
    localparam int DAYS_PER_ERA = 146097;
    localparam int ERA_W        = 5;
    localparam int DOE_W        = 18;
    localparam int TMIN_W       = 11;
    localparam int SIXTY        = 60;
    localparam int HOUR_W       = 5;
    localparam int MIN_W        = 6;
    localparam int DIV_1460     = 1460;
    localparam int Q1460_W      = 7;
    localparam int YEAR_DAYS    = 365;
    localparam int YOE_W        = 9;
    localparam int DOY_W        = 9;
    localparam int MPX_W        = 11;
    localparam int DIV_153      = 153;
    localparam int MP_W         = 4;
    localparam int DAY_W        = 5;
    localparam int MONTH_W      = 4;
    localparam int YEAR_W       = 14;
    localparam int YEARS_PER_ERA = 400;
    localparam int PACK_YEAR_MAX = 4095;

    typedef struct packed {
        logic [HI_W-1:0] hi;
        logic [LO_W-1:0] lo;
    } s1_t;

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [TOD_W-1:0]  tod;
    } s2_t;

    typedef struct packed {
        logic [DAYS_W-1:0] z;
        logic [TOD_W-1:0]  tod;
    } s3_t;

    typedef struct packed {
        logic [ERA_W-1:0]  era;
        logic [DOE_W-1:0]  doe;
        logic [TMIN_W-1:0] tmin;
        logic [MIN_W-1:0]  sec;
    } s4_t;

    typedef s4_t s5_t;

    typedef struct packed {
        logic [ERA_W-1:0]  era;
        logic [DOE_W-1:0]  doe;
        logic [DOE_W-1:0]  n;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [MIN_W-1:0]  sec;
    } s6_t;

    typedef s6_t s7_t;

    typedef struct packed {
        logic [ERA_W-1:0]  era;
        logic [DOE_W-1:0]  doe;
        logic [YOE_W-1:0]  yoe;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [MIN_W-1:0]  sec;
    } s8_t;

    typedef struct packed {
        logic [ERA_W-1:0]  era;
        logic [YOE_W-1:0]  yoe;
        logic [DOY_W-1:0]  doy;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [MIN_W-1:0]  sec;
    } s9_t;

    typedef struct packed {
        logic [ERA_W-1:0]  era;
        logic [YOE_W-1:0]  yoe;
        logic [DOY_W-1:0]  doy;
        logic [MPX_W-1:0]  x;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [MIN_W-1:0]  sec;
    } s10_t;

    typedef struct packed {
        logic [ERA_W-1:0]  era;
        logic [YOE_W-1:0]  yoe;
        logic [DOY_W-1:0]  doy;
        logic [MP_W-1:0]   mp;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [MIN_W-1:0]  sec;
    } s11_t;

    typedef struct packed {
        logic [31:0] month_year;
        logic [31:0] hour_day;
        logic [31:0] second_minute;
        logic [31:0] packed_time;
    } out_t;

    // day-of-era / 36524, one step per full century boundary
    function automatic logic [2:0] century_adj(input logic [DOE_W-1:0] doe);
        logic [2:0] c;
        c = 3'd0;
        if (doe >= DOE_W'(36524))
        begin
            c = 3'd1;
        end
        if (doe >= DOE_W'(73048))
        begin
            c = 3'd2;
        end
        if (doe >= DOE_W'(109572))
        begin
            c = 3'd3;
        end
        if (doe >= DOE_W'(146096))
        begin
            c = 3'd4;
        end
        return c;
    endfunction

    function automatic logic [1:0] yoe_div100(input logic [YOE_W-1:0] yoe);
        logic [1:0] c;
        c = 2'd0;
        if (yoe >= YOE_W'(100))
        begin
            c = 2'd1;
        end
        if (yoe >= YOE_W'(200))
        begin
            c = 2'd2;
        end
        if (yoe >= YOE_W'(300))
        begin
            c = 2'd3;
        end
        return c;
    endfunction

    // first day-of-year of each March-based month: (153 * mp + 2) / 5
    function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] d;
        case (mp)
            4'd0:    d = DOY_W'(0);
            4'd1:    d = DOY_W'(31);
            4'd2:    d = DOY_W'(61);
            4'd3:    d = DOY_W'(92);
            4'd4:    d = DOY_W'(122);
            4'd5:    d = DOY_W'(153);
            4'd6:    d = DOY_W'(184);
            4'd7:    d = DOY_W'(214);
            4'd8:    d = DOY_W'(245);
            4'd9:    d = DOY_W'(275);
            4'd10:   d = DOY_W'(306);
            4'd11:   d = DOY_W'(337);
            default: d = DOY_W'(0);
        endcase
        return d;
    endfunction

endpackage

// File: sv/ecw_stage.sv
`timescale 1ns / 1ps

module ecw_stage #(
    parameter type T = logic
) (
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    input  T     up_data,
    output logic up_ready,
    input  logic dn_ready,
    output logic dn_valid,
    output T     dn_data,
    output logic load
);

    logic valid_reg;
    logic valid_next;
    T     data_reg;

    assign up_ready   = !valid_reg || dn_ready;
    assign load       = up_ready && up_valid;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= up_data;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: sv/ecw_cdiv.sv
`timescale 1ns / 1ps

// constant divider: reciprocal product registered, then one correction step
module ecw_cdiv #(
    parameter int XW  = 8,
    parameter int QW  = 8,
    parameter int RW  = 8,
    parameter int DIV = 3
) (
    input  logic          clk,
    input  logic          load,
    input  logic [XW-1:0] x_in,
    input  logic [XW-1:0] x_reg,
    output logic [QW-1:0] q,
    output logic [RW-1:0] r
);

    localparam longint unsigned MUL = (64'd1 << XW) / DIV;
    localparam int MW = $clog2(MUL + 1);
    localparam int PW = XW + MW;

    logic [PW-1:0] prod_reg;
    logic [PW-1:0] prod_next;
    logic [MW-1:0] q_est;
    logic [RW:0]   r_est;
    logic          fix;

    assign prod_next = PW'(x_in) * PW'(MUL);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    // estimate is exact or one low
    assign q_est = prod_reg[PW-1:XW];
    assign r_est = (RW+1)'(x_reg) - (RW+1)'(q_est) * (RW+1)'(DIV);
    assign fix   = r_est >= (RW+1)'(DIV);
    assign q     = QW'(q_est) + QW'(fix);
    assign r     = fix ? RW'(r_est - (RW+1)'(DIV)) : RW'(r_est);

endmodule

// File: sv/epoch_seconds_to_calendar_words_top.sv
`timescale 1ns / 1ps

// Converts whole seconds since 1970-01-01 00:00 UTC (38 bits) into a proleptic
// Gregorian date and time of day, given both as three half-word pairs
// (month/year, hour/day, second/minute) and as one packed word with the year
// saturated at 4095. Twelve register stages; one transaction is taken every
// cycle while the output is not stalled. Each divider (ecw_cdiv) divides by a
// constant, done as a registered reciprocal product followed by a single
// correction in the next stage. A stall on the output only backs up the
// pipeline as far as it is full, so empty stages keep taking input.
module epoch_seconds_to_calendar_words_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        epoch_valid,
    output logic        epoch_stall,
    input  logic [37:0] epoch_seconds,
    output logic        word_valid,
    input  logic        word_stall,
    output logic [31:0] month_year_word,
    output logic [31:0] hour_day_word,
    output logic [31:0] second_minute_word,
    output logic [31:0] packed_time_word
);

    ecw_pkg::s1_t  s1_next,  s1;
    ecw_pkg::s2_t  s2_next,  s2;
    ecw_pkg::s3_t  s3_next,  s3;
    ecw_pkg::s4_t  s4_next,  s4;
    ecw_pkg::s5_t  s5;
    ecw_pkg::s6_t  s6_next,  s6;
    ecw_pkg::s7_t  s7;
    ecw_pkg::s8_t  s8_next,  s8;
    ecw_pkg::s9_t  s9_next,  s9;
    ecw_pkg::s10_t s10_next, s10;
    ecw_pkg::s11_t s11_next, s11;
    ecw_pkg::out_t o_next,   o;

    logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12;
    logic r1, r2, r3, r4, r5, r6, r7, r8, r9, r10, r11, r12;
    logic ld1, ld2, ld3, ld4, ld5, ld6, ld7, ld8, ld9, ld10, ld11, ld12;

    logic [ecw_pkg::DAYS_W-1:0]  days_q;
    logic [9:0]                  day_r;
    logic [ecw_pkg::ERA_W-1:0]   era_q;
    logic [ecw_pkg::DOE_W-1:0]   doe_r;
    logic [ecw_pkg::TMIN_W-1:0]  tmin_q;
    logic [ecw_pkg::MIN_W-1:0]   sec_r;
    logic [ecw_pkg::Q1460_W-1:0] q1460;
    logic [10:0]                 r1460;
    logic [ecw_pkg::HOUR_W-1:0]  hour_q;
    logic [ecw_pkg::MIN_W-1:0]   min_r;
    logic [ecw_pkg::YOE_W-1:0]   yoe_q;
    logic [8:0]                  yoe_r;
    logic [ecw_pkg::MP_W-1:0]    mp_q;
    logic [7:0]                  mp_r;
    logic [ecw_pkg::DAY_W-1:0]   day_v;
    logic [ecw_pkg::MONTH_W-1:0] month_v;
    logic [ecw_pkg::YEAR_W-1:0]  year_v;
    logic [11:0]                 year_sat;

    assign epoch_stall = !r1;

    // stage 1: seconds / 86400 done as (seconds >> 7) / 675
    assign s1_next.hi = epoch_seconds[ecw_pkg::EPOCH_W-1:ecw_pkg::LO_W];
    assign s1_next.lo = epoch_seconds[ecw_pkg::LO_W-1:0];

    ecw_stage #(.T(ecw_pkg::s1_t)) u_st1 (
        .clk(clk), .rst_n(rst_n), .up_valid(epoch_valid), .up_data(s1_next), .up_ready(r1),
        .dn_ready(r2), .dn_valid(v1), .dn_data(s1), .load(ld1)
    );

    ecw_cdiv #(.XW(ecw_pkg::HI_W), .QW(ecw_pkg::DAYS_W), .RW(10), .DIV(ecw_pkg::DAY_DIV))
        u_div_day (
        .clk(clk), .load(ld1), .x_in(s1_next.hi), .x_reg(s1.hi), .q(days_q), .r(day_r)
    );

    // stage 2
    assign s2_next.days = days_q;
    assign s2_next.tod  = {day_r, s1.lo};

    ecw_stage #(.T(ecw_pkg::s2_t)) u_st2 (
        .clk(clk), .rst_n(rst_n), .up_valid(v1), .up_data(s2_next), .up_ready(r2),
        .dn_ready(r3), .dn_valid(v2), .dn_data(s2), .load(ld2)
    );

    // stage 3: era split and minute split
    assign s3_next.z   = s2.days + ecw_pkg::DAYS_W'(ecw_pkg::DAYS_TO_ERA0);
    assign s3_next.tod = s2.tod;

    ecw_stage #(.T(ecw_pkg::s3_t)) u_st3 (
        .clk(clk), .rst_n(rst_n), .up_valid(v2), .up_data(s3_next), .up_ready(r3),
        .dn_ready(r4), .dn_valid(v3), .dn_data(s3), .load(ld3)
    );

    ecw_cdiv #(.XW(ecw_pkg::DAYS_W), .QW(ecw_pkg::ERA_W), .RW(ecw_pkg::DOE_W),
        .DIV(ecw_pkg::DAYS_PER_ERA)) u_div_era (
        .clk(clk), .load(ld3), .x_in(s3_next.z), .x_reg(s3.z), .q(era_q), .r(doe_r)
    );

    ecw_cdiv #(.XW(ecw_pkg::TOD_W), .QW(ecw_pkg::TMIN_W), .RW(ecw_pkg::MIN_W),
        .DIV(ecw_pkg::SIXTY)) u_div_min (
        .clk(clk), .load(ld3), .x_in(s3_next.tod), .x_reg(s3.tod), .q(tmin_q), .r(sec_r)
    );

    // stage 4
    assign s4_next.era  = era_q;
    assign s4_next.doe  = doe_r;
    assign s4_next.tmin = tmin_q;
    assign s4_next.sec  = sec_r;

    ecw_stage #(.T(ecw_pkg::s4_t)) u_st4 (
        .clk(clk), .rst_n(rst_n), .up_valid(v3), .up_data(s4_next), .up_ready(r4),
        .dn_ready(r5), .dn_valid(v4), .dn_data(s4), .load(ld4)
    );

    // stage 5: doe / 1460 and hour split
    ecw_stage #(.T(ecw_pkg::s5_t)) u_st5 (
        .clk(clk), .rst_n(rst_n), .up_valid(v4), .up_data(s4), .up_ready(r5),
        .dn_ready(r6), .dn_valid(v5), .dn_data(s5), .load(ld5)
    );

    ecw_cdiv #(.XW(ecw_pkg::DOE_W), .QW(ecw_pkg::Q1460_W), .RW(11),
        .DIV(ecw_pkg::DIV_1460)) u_div_1460 (
        .clk(clk), .load(ld5), .x_in(s4.doe), .x_reg(s5.doe), .q(q1460), .r(r1460)
    );

    ecw_cdiv #(.XW(ecw_pkg::TMIN_W), .QW(ecw_pkg::HOUR_W), .RW(ecw_pkg::MIN_W),
        .DIV(ecw_pkg::SIXTY)) u_div_hour (
        .clk(clk), .load(ld5), .x_in(s4.tmin), .x_reg(s5.tmin), .q(hour_q), .r(min_r)
    );

    // stage 6: leap-adjusted day count of the era
    assign s6_next.era    = s5.era;
    assign s6_next.doe    = s5.doe;
    assign s6_next.n      = s5.doe - ecw_pkg::DOE_W'(q1460)
                          + ecw_pkg::DOE_W'(ecw_pkg::century_adj(s5.doe))
                          - ecw_pkg::DOE_W'(s5.doe == ecw_pkg::DOE_W'(146096));
    assign s6_next.hour   = hour_q;
    assign s6_next.minute = min_r;
    assign s6_next.sec    = s5.sec;

    ecw_stage #(.T(ecw_pkg::s6_t)) u_st6 (
        .clk(clk), .rst_n(rst_n), .up_valid(v5), .up_data(s6_next), .up_ready(r6),
        .dn_ready(r7), .dn_valid(v6), .dn_data(s6), .load(ld6)
    );

    // stage 7: year of era
    ecw_stage #(.T(ecw_pkg::s7_t)) u_st7 (
        .clk(clk), .rst_n(rst_n), .up_valid(v6), .up_data(s6), .up_ready(r7),
        .dn_ready(r8), .dn_valid(v7), .dn_data(s7), .load(ld7)
    );

    ecw_cdiv #(.XW(ecw_pkg::DOE_W), .QW(ecw_pkg::YOE_W), .RW(9),
        .DIV(ecw_pkg::YEAR_DAYS)) u_div_yoe (
        .clk(clk), .load(ld7), .x_in(s6.n), .x_reg(s7.n), .q(yoe_q), .r(yoe_r)
    );

    // stage 8
    assign s8_next.era    = s7.era;
    assign s8_next.doe    = s7.doe;
    assign s8_next.yoe    = yoe_q;
    assign s8_next.hour   = s7.hour;
    assign s8_next.minute = s7.minute;
    assign s8_next.sec    = s7.sec;

    ecw_stage #(.T(ecw_pkg::s8_t)) u_st8 (
        .clk(clk), .rst_n(rst_n), .up_valid(v7), .up_data(s8_next), .up_ready(r8),
        .dn_ready(r9), .dn_valid(v8), .dn_data(s8), .load(ld8)
    );

    // stage 9: day of year
    logic [ecw_pkg::DOE_W-1:0] doy_full;

    assign doy_full = s8.doe
                    - ecw_pkg::DOE_W'(s8.yoe) * ecw_pkg::DOE_W'(ecw_pkg::YEAR_DAYS)
                    - ecw_pkg::DOE_W'(s8.yoe >> 2)
                    + ecw_pkg::DOE_W'(ecw_pkg::yoe_div100(s8.yoe));

    assign s9_next.era    = s8.era;
    assign s9_next.yoe    = s8.yoe;
    assign s9_next.doy    = doy_full[ecw_pkg::DOY_W-1:0];
    assign s9_next.hour   = s8.hour;
    assign s9_next.minute = s8.minute;
    assign s9_next.sec    = s8.sec;

    ecw_stage #(.T(ecw_pkg::s9_t)) u_st9 (
        .clk(clk), .rst_n(rst_n), .up_valid(v8), .up_data(s9_next), .up_ready(r9),
        .dn_ready(r10), .dn_valid(v9), .dn_data(s9), .load(ld9)
    );

    // stage 10: March-based month index
    assign s10_next.era    = s9.era;
    assign s10_next.yoe    = s9.yoe;
    assign s10_next.doy    = s9.doy;
    assign s10_next.x      = ecw_pkg::MPX_W'(s9.doy) * ecw_pkg::MPX_W'(5) + ecw_pkg::MPX_W'(2);
    assign s10_next.hour   = s9.hour;
    assign s10_next.minute = s9.minute;
    assign s10_next.sec    = s9.sec;

    ecw_stage #(.T(ecw_pkg::s10_t)) u_st10 (
        .clk(clk), .rst_n(rst_n), .up_valid(v9), .up_data(s10_next), .up_ready(r10),
        .dn_ready(r11), .dn_valid(v10), .dn_data(s10), .load(ld10)
    );

    ecw_cdiv #(.XW(ecw_pkg::MPX_W), .QW(ecw_pkg::MP_W), .RW(8),
        .DIV(ecw_pkg::DIV_153)) u_div_mp (
        .clk(clk), .load(ld10), .x_in(s10_next.x), .x_reg(s10.x), .q(mp_q), .r(mp_r)
    );

    // stage 11
    assign s11_next.era    = s10.era;
    assign s11_next.yoe    = s10.yoe;
    assign s11_next.doy    = s10.doy;
    assign s11_next.mp     = mp_q;
    assign s11_next.hour   = s10.hour;
    assign s11_next.minute = s10.minute;
    assign s11_next.sec    = s10.sec;

    ecw_stage #(.T(ecw_pkg::s11_t)) u_st11 (
        .clk(clk), .rst_n(rst_n), .up_valid(v10), .up_data(s11_next), .up_ready(r11),
        .dn_ready(r12), .dn_valid(v11), .dn_data(s11), .load(ld11)
    );

    // stage 12: output words
    logic [ecw_pkg::DOY_W-1:0] day_full;

    assign day_full = s11.doy - ecw_pkg::month_start(s11.mp) + ecw_pkg::DOY_W'(1);
    assign day_v    = day_full[ecw_pkg::DAY_W-1:0];
    assign month_v  = (s11.mp < ecw_pkg::MP_W'(10)) ? s11.mp + ecw_pkg::MP_W'(3)
                                                    : s11.mp - ecw_pkg::MP_W'(9);
    assign year_v   = ecw_pkg::YEAR_W'(s11.era) * ecw_pkg::YEAR_W'(ecw_pkg::YEARS_PER_ERA)
                    + ecw_pkg::YEAR_W'(s11.yoe)
                    + ecw_pkg::YEAR_W'(month_v <= ecw_pkg::MONTH_W'(2));
    assign year_sat = (year_v > ecw_pkg::YEAR_W'(ecw_pkg::PACK_YEAR_MAX))
                    ? 12'(ecw_pkg::PACK_YEAR_MAX) : year_v[11:0];

    assign o_next.month_year    = {16'(month_v), 16'(year_v)};
    assign o_next.hour_day      = {16'(s11.hour), 16'(day_v)};
    assign o_next.second_minute = {16'(s11.sec), 16'(s11.minute)};
    assign o_next.packed_time   = {s11.minute, s11.hour, day_v, month_v, year_sat};

    ecw_stage #(.T(ecw_pkg::out_t)) u_st12 (
        .clk(clk), .rst_n(rst_n), .up_valid(v11), .up_data(o_next), .up_ready(r12),
        .dn_ready(!word_stall), .dn_valid(v12), .dn_data(o), .load(ld12)
    );

    assign word_valid         = v12;
    assign month_year_word    = o.month_year;
    assign hour_day_word      = o.hour_day;
    assign second_minute_word = o.second_minute;
    assign packed_time_word   = o.packed_time;

    // input held off only when every stage is full and the output is stalled
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_stall |-> (v1 && v2 && v3 && v4 && v5 && v6 && v7 && v8 && v9 && v10 && v11
                         && v12 && word_stall))
        else $error("input stalled with room in the pipeline");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |-> (month_year_word[31:16] >= 16'd1 && month_year_word[31:16] <= 16'd12
                        && hour_day_word[15:0] >= 16'd1 && hour_day_word[15:0] <= 16'd31))
        else $error("month or day out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |-> (hour_day_word[31:16] < 16'd24 && second_minute_word[31:16] < 16'd60
                        && second_minute_word[15:0] < 16'd60))
        else $error("time of day out of range");

    a_pack_match: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |->
            (packed_time_word[31:26] == second_minute_word[5:0]
             && packed_time_word[25:21] == hour_day_word[20:16]
             && packed_time_word[20:16] == hour_day_word[4:0]
             && packed_time_word[15:12] == month_year_word[19:16]))
        else $error("packed word disagrees with half-word encoding");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!v5 || r1460 < 11'd1460) && (!v7 || yoe_r < 9'd365) && (!v10 || mp_r < 8'd153))
        else $error("divider remainder out of range");

    // a held transaction is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !((ld1 && v1 && !r2) || (ld2 && v2 && !r3) || (ld3 && v3 && !r4)
          || (ld4 && v4 && !r5) || (ld5 && v5 && !r6) || (ld6 && v6 && !r7)
          || (ld7 && v7 && !r8) || (ld8 && v8 && !r9) || (ld9 && v9 && !r10)
          || (ld10 && v10 && !r11) || (ld11 && v11 && !r12)
          || (ld12 && v12 && word_stall)))
        else $error("stalled stage overwritten");

endmodule
